// ===== rtl/dsp_pkg.sv =====
// shared types and constants for the dual servo pulse generator
`default_nettype none

package dsp_pkg;

  localparam int KIND_W     = 2;
  localparam int ANGLE_W    = 8;
  localparam int PULSE_W    = 5;
  localparam int COUNT_W    = 8;
  localparam int SUB_MS_W   = 4;
  localparam int MS_W       = 32;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SET_H = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SET_V = 2'd2;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -8'sd90;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 8'sd90;

  // pulse numerator is CENTER_NUM +/- DEG_GAIN * angle, then divided by 100
  localparam int NUM_W = 13;
  localparam logic signed [NUM_W-1:0] CENTER_NUM = 13'sd1500;
  localparam logic signed [NUM_W-1:0] DEG_GAIN   = 13'sd11;

  // divide by 100 as multiply by 5243 / 2^19, exact for numerators below 4096
  localparam int DIV_IN_W    = 12;
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int PROD_W = DIV_IN_W + RECIP_W;

  localparam logic [PULSE_W-1:0] PULSE_CENTER = 5'd15;

  typedef struct packed {
    logic               tick;
    logic               load;
    logic [PULSE_W-1:0] pulse;
  } chan_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/dsp_if.sv =====
// command and result channel interfaces
`default_nettype none

interface dsp_cmd_if;
  import dsp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [ANGLE_W-1:0] angle_deg;

  modport source (output valid, kind, angle_deg, input ready);
  modport sink   (input valid, kind, angle_deg, output ready);
endinterface

interface dsp_res_if;
  import dsp_pkg::*;
  logic            valid;
  logic            ready;
  logic            servo_h_level;
  logic            servo_v_level;
  logic [MS_W-1:0] ms_count;
  logic            angle_taken;

  modport source (output valid, servo_h_level, servo_v_level, ms_count, angle_taken,
                  input ready);
  modport sink   (input valid, servo_h_level, servo_v_level, ms_count, angle_taken,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/dsp_pulse_conv.sv =====
// angle in degrees to pulse length in ticks
`default_nettype none

module dsp_pulse_conv
  import dsp_pkg::*;
(
  input  wire logic signed [ANGLE_W-1:0] angle_deg,
  input  wire logic                      invert,
  output logic                           in_range,
  output logic [PULSE_W-1:0]             pulse
);

  logic signed [ANGLE_W:0]   angle_eff;
  logic signed [NUM_W-1:0]   num;
  logic [PROD_W-1:0]         prod;

  always_comb begin
    in_range  = (angle_deg >= ANGLE_MIN) && (angle_deg <= ANGLE_MAX);
    angle_eff = invert ? -$signed({angle_deg[ANGLE_W-1], angle_deg})
                       : $signed({angle_deg[ANGLE_W-1], angle_deg});
    num  = CENTER_NUM
         + $signed({{(NUM_W-ANGLE_W-1){angle_eff[ANGLE_W]}}, angle_eff}) * DEG_GAIN;
    // numerator is positive and below 4096 when the angle is in range
    prod  = PROD_W'(num[DIV_IN_W-1:0]) * PROD_W'(RECIP_100);
    pulse = prod[RECIP_SHIFT +: PULSE_W];
  end

endmodule

`default_nettype wire

// ===== rtl/dsp_servo_chan.sv =====
// one servo channel: period counter, pulse length and output level
`default_nettype none

module dsp_servo_chan
  import dsp_pkg::*;
#(
  parameter int PERIOD_LIMIT = 200
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire chan_ctl_t ctl,
  output logic           level_next
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [PULSE_W-1:0] pulse_len;
  logic               level;

  always_comb begin
    count_next = count;
    level_next = level;
    if (ctl.tick) begin
      if (count > COUNT_W'(PERIOD_LIMIT)) begin
        // restart: level held for this tick
        count_next = COUNT_W'(1);
      end else begin
        level_next = (count <= COUNT_W'(pulse_len));
        count_next = count + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pulse_len <= PULSE_CENTER;
      level     <= 1'b0;
    end else begin
      count <= count_next;
      level <= level_next;
      if (ctl.load) begin
        pulse_len <= ctl.pulse;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dual_servo_pwm_generator_core.sv =====
// top level: input register, servo channels, millisecond timer, result register
//
//  channel | dir | handshake     | payload
//  cmd     | in  | valid / ready | kind[1:0], angle_deg[7:0] signed
//  res     | out | valid / ready | servo_h_level, servo_v_level, ms_count[31:0], angle_taken
//
// one item per cycle sustained while res is not stalled; res valid follows the cmd transfer
// through the input register, then state update and result register
// rst clears counters and levels, sets both pulse lengths to the centre value 15
// a stalled result holds the result register; the input register still fills,
// and cmd.ready drops only while both stages are full and res is stalled
`default_nettype none

module dual_servo_pwm_generator_core
  import dsp_pkg::*;
#(
  parameter int PERIOD_LIMIT = 200,
  parameter int TICKS_PER_MS = 10
) (
  input  wire logic   clk,
  input  wire logic   rst,
  dsp_cmd_if.sink     cmd,
  dsp_res_if.source   res
);

  // input register
  logic                      s1_valid;
  logic [KIND_W-1:0]         s1_kind;
  logic signed [ANGLE_W-1:0] s1_angle;
  logic                      s1_adv;

  assign s1_adv    = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      s1_kind  <= cmd.kind;
      s1_angle <= cmd.angle_deg;
    end
  end

  // angle conversion
  logic               is_h;
  logic               is_v;
  logic               is_tick;
  logic               in_range;
  logic [PULSE_W-1:0] pulse;

  assign is_tick = (s1_kind == KIND_TICK);
  assign is_h    = (s1_kind == KIND_SET_H);
  assign is_v    = (s1_kind == KIND_SET_V);

  dsp_pulse_conv u_conv (
    .angle_deg (s1_angle),
    .invert    (is_h),
    .in_range  (in_range),
    .pulse     (pulse)
  );

  chan_ctl_t ctl_h;
  chan_ctl_t ctl_v;
  logic      level_h_next;
  logic      level_v_next;

  always_comb begin
    ctl_h.tick  = s1_adv && is_tick;
    ctl_h.load  = s1_adv && is_h && in_range;
    ctl_h.pulse = pulse;
    ctl_v.tick  = s1_adv && is_tick;
    ctl_v.load  = s1_adv && is_v && in_range;
    ctl_v.pulse = pulse;
  end

  dsp_servo_chan #(.PERIOD_LIMIT(PERIOD_LIMIT)) u_chan_h (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_h),
    .level_next (level_h_next)
  );

  dsp_servo_chan #(.PERIOD_LIMIT(PERIOD_LIMIT)) u_chan_v (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl_v),
    .level_next (level_v_next)
  );

  // millisecond timer
  logic [SUB_MS_W-1:0] sub_ms;
  logic [SUB_MS_W-1:0] sub_ms_next;
  logic [MS_W-1:0]     millis;
  logic [MS_W-1:0]     millis_next;

  always_comb begin
    sub_ms_next = sub_ms;
    millis_next = millis;
    if (s1_adv && is_tick) begin
      sub_ms_next = sub_ms + SUB_MS_W'(1);
      if (sub_ms_next >= SUB_MS_W'(TICKS_PER_MS)) begin
        sub_ms_next = '0;
        millis_next = millis + MS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_ms <= '0;
      millis <= '0;
    end else begin
      sub_ms <= sub_ms_next;
      millis <= millis_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_adv) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
    if (s1_adv) begin
      res.servo_h_level <= level_h_next;
      res.servo_v_level <= level_v_next;
      res.ms_count      <= millis_next;
      res.angle_taken   <= (is_h || is_v) && in_range;
    end
  end

  // checks
  a_tick_no_taken: assert property (@(posedge clk) disable iff (rst)
    s1_adv && is_tick |=> !res.angle_taken)
    else $error("angle_taken set on a tick");

  a_millis_only_on_tick: assert property (@(posedge clk) disable iff (rst)
    !(s1_adv && is_tick) |=> $stable(millis))
    else $error("millisecond count moved without a tick");

  a_sub_ms_bound: assert property (@(posedge clk) disable iff (rst)
    sub_ms < SUB_MS_W'(TICKS_PER_MS))
    else $error("sub-millisecond count out of range");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res.valid |-> cmd.ready)
    else $error("input stalled with an empty result register");

endmodule

`default_nettype wire
